[src/drjq_pkg.sv]
// ----------------------------------------------------------------------------
// drjq_pkg: shared definitions for the dispatch rule job queue
// Sizes, rule and status codes, and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package drjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int JOB_BITS    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int JOB_W  = 8;
    localparam int TIME_W = 16;
    localparam int WAIT_W = 20;
    localparam int RND_W  = 16;
    localparam int RULE_W = 3;
    localparam int STAT_W = 2;
    localparam int RBIT_W = $clog2(RND_W);
    localparam int WT_W   = WAIT_W + 2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    localparam logic [RULE_W-1:0] RULE_RANDOM   = 3'd0;
    localparam logic [RULE_W-1:0] RULE_FIFO     = 3'd1;
    localparam logic [RULE_W-1:0] RULE_SHORTEST = 3'd2;
    localparam logic [RULE_W-1:0] RULE_AGED     = 3'd3;
    localparam logic [RULE_W-1:0] RULE_LONGEST  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_ADDED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PICKED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_PICK = 1'b1;

    typedef struct packed {
        logic [JOB_BITS-1:0] job;
        logic [TIME_W-1:0]   ptime;
        logic [WAIT_W-1:0]   wait_t;
    } t_entry;

    typedef struct packed {
        logic              load;
        logic              add_wr;
        logic              mod_init;
        logic              mod_step;
        logic              scan_init;
        logic              scan_rd;
        logic              fetch_rd;
        logic              fetch_cap;
        logic              move_init;
        logic              move_rd;
        logic              count_dec;
        logic              out_load;
        logic [STAT_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic empty;
        logic full;
        logic rule_rand;
        logic rule_scan;
        logic scan_more;
        logic move_more;
        logic mod_last;
        logic out_free;
    } t_dp_stat;

endpackage

[src/drjq_ctrl.sv]
// ----------------------------------------------------------------------------
// drjq_ctrl: sequencer of the job queue
// Add, modulo, scan, fetch, compaction and result phases of each transfer.
// ----------------------------------------------------------------------------
module drjq_ctrl import drjq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MOD, S_SCAN, S_FETCH, S_FETCH_WAIT, S_MOVE, S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [STAT_W-1:0] r_res, n_res;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.status = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.op == OP_ADD) begin
                    n_state = S_DONE;
                    if (i_stat.full) begin
                        n_res = STAT_FULL;
                    end else begin
                        n_res        = STAT_ADDED;
                        o_cmd.add_wr = 1'b1;
                    end
                end else if (i_stat.empty) begin
                    n_res   = STAT_EMPTY;
                    n_state = S_DONE;
                end else if (i_stat.rule_rand) begin
                    o_cmd.mod_init = 1'b1;
                    n_state        = S_MOD;
                end else if (i_stat.rule_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_FETCH;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan_rd = 1'b1;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch_rd = 1'b1;
                n_state        = S_FETCH_WAIT;
            end
            S_FETCH_WAIT: begin
                o_cmd.fetch_cap = 1'b1;
                o_cmd.move_init = 1'b1;
                n_state         = S_MOVE;
            end
            S_MOVE: begin
                if (i_stat.move_more) begin
                    o_cmd.move_rd = 1'b1;
                end else begin
                    o_cmd.count_dec = 1'b1;
                    n_res           = STAT_PICKED;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= STAT_ADDED;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

endmodule

[src/drjq_dp.sv]
// ----------------------------------------------------------------------------
// drjq_dp: datapath of the job queue
// Entry memory, count, modulo unit, best-entry tracker and output register.
// ----------------------------------------------------------------------------
module drjq_dp import drjq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_cfg_valid,
    input  logic [RULE_W-1:0]   i_cfg_rule,
    input  logic                i_op,
    input  logic [JOB_W-1:0]    i_job,
    input  logic [TIME_W-1:0]   i_ptime,
    input  logic [WAIT_W-1:0]   i_wait,
    input  logic [RND_W-1:0]    i_rnd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STAT_W-1:0]   o_out_status,
    output logic [JOB_W-1:0]    o_out_job,
    output logic [TIME_W-1:0]   o_out_time
);

    t_entry mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    logic [RULE_W-1:0]   r_rule;
    logic [CNT_W-1:0]    r_count;
    logic                r_op;
    t_entry              r_in;
    logic [RND_W-1:0]    r_rnd;
    logic [CNT_W-1:0]    r_ptr;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_scan_vld;
    logic                r_move_vld;
    logic [CNT_W-1:0]    r_rem;
    logic [RBIT_W-1:0]   r_rbit;
    logic [IDX_W-1:0]    r_best_idx;
    logic [TIME_W-1:0]   r_best_time;
    logic signed [WT_W-1:0] r_best_wt;
    logic [IDX_W-1:0]    r_sel;
    logic [JOB_BITS-1:0] r_pick_job;
    logic [TIME_W-1:0]   r_pick_time;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    logic [JOB_W-1:0]    r_out_job;
    logic [TIME_W-1:0]   r_out_time;

    logic                   aging;
    logic [CNT_W:0]         rem_sh;
    logic [CNT_W-1:0]       rem_nx;
    logic signed [WT_W-1:0] rd_wt;
    logic                   better;
    logic [IDX_W-1:0]       sel_nx;
    logic [CNT_W-1:0]       move_src;
    logic [WAIT_W:0]        wait_sum;
    logic [WAIT_W-1:0]      wait_nx;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;

    assign aging = (r_rule == RULE_AGED);

    // One bit of the random value per cycle into the remainder, most significant bit first.
    assign rem_sh = {r_rem, r_rnd[RND_W-1-int'(r_rbit)]};
    assign rem_nx = (rem_sh >= {1'b0, r_count}) ? CNT_W'(rem_sh - {1'b0, r_count})
                                                : CNT_W'(rem_sh);

    assign rd_wt = $signed({{(WT_W-TIME_W){1'b0}}, r_rd_data.ptime})
                 - $signed({{(WT_W-WAIT_W){1'b0}}, r_rd_data.wait_t});

    always_comb begin
        case (r_rule)
            RULE_SHORTEST: better = r_rd_data.ptime < r_best_time;
            RULE_AGED:     better = rd_wt < r_best_wt;
            RULE_LONGEST:  better = r_rd_data.ptime > r_best_time;
            default:       better = 1'b0;
        endcase
    end

    always_comb begin
        case (r_rule)
            RULE_RANDOM:                            sel_nx = r_rem[IDX_W-1:0];
            RULE_SHORTEST, RULE_AGED, RULE_LONGEST: sel_nx = r_best_idx;
            default:                                sel_nx = '0;
        endcase
    end

    assign move_src = (r_ptr >= CNT_W'(r_sel)) ? r_ptr + CNT_W'(1) : r_ptr;
    assign wait_sum = {1'b0, r_rd_data.wait_t} + (WAIT_W+1)'(r_pick_time);
    assign wait_nx  = !aging ? r_rd_data.wait_t
                    : (wait_sum > {1'b0, WAIT_MAX}) ? WAIT_MAX : wait_sum[WAIT_W-1:0];

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_ptr[IDX_W-1:0];
        if (i_cmd.fetch_rd) begin
            rd_addr = sel_nx;
        end else if (i_cmd.move_rd) begin
            rd_addr = move_src[IDX_W-1:0];
        end else if (!i_cmd.scan_rd) begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.add_wr) begin
            mem[r_count[IDX_W-1:0]] <= r_in;
        end else if (r_move_vld) begin
            mem[r_rd_idx] <= '{job: r_rd_data.job, ptime: r_rd_data.ptime, wait_t: wait_nx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_in <= '{job: i_job[JOB_BITS-1:0], ptime: i_ptime, wait_t: i_wait};
            r_rnd <= i_rnd;
        end
        if (i_cmd.mod_init) begin
            r_rem  <= '0;
            r_rbit <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem  <= rem_nx;
            r_rbit <= r_rbit + RBIT_W'(1);
        end
        if (r_scan_vld && (r_rd_idx == '0 || better)) begin
            r_best_idx  <= r_rd_idx;
            r_best_time <= r_rd_data.ptime;
            r_best_wt   <= rd_wt;
        end
        if (i_cmd.fetch_rd) begin
            r_sel <= sel_nx;
        end
        if (i_cmd.fetch_cap) begin
            r_pick_job  <= r_rd_data.job;
            r_pick_time <= r_rd_data.ptime;
        end
        if (i_cmd.scan_rd || i_cmd.move_rd) begin
            r_rd_idx <= r_ptr[IDX_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_job    <= (i_cmd.status == STAT_PICKED) ? JOB_W'(r_pick_job) : '0;
            r_out_time   <= (i_cmd.status == STAT_PICKED) ? r_pick_time : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule      <= RULE_FIFO;
            r_count     <= '0;
            r_ptr       <= '0;
            r_scan_vld  <= 1'b0;
            r_move_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rule <= i_cfg_rule;
            end
            if (i_cmd.add_wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.scan_init) begin
                r_ptr <= '0;
            end else if (i_cmd.move_init) begin
                r_ptr <= aging ? '0 : CNT_W'(r_sel);
            end else if (i_cmd.scan_rd || i_cmd.move_rd) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            r_scan_vld <= i_cmd.scan_rd;
            r_move_vld <= i_cmd.move_rd;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.rule_rand = (r_rule == RULE_RANDOM);
    assign o_stat.rule_scan = (r_rule == RULE_SHORTEST) || aging || (r_rule == RULE_LONGEST);
    assign o_stat.scan_more = (r_ptr < r_count);
    assign o_stat.move_more = ((r_ptr + CNT_W'(1)) < r_count);
    assign o_stat.mod_last  = (r_rbit == RBIT_W'(RND_W - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_job    = r_out_job;
    assign o_out_time   = r_out_time;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");
    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_wr |-> (r_count != CNT_W'(QUEUE_DEPTH)))
        else $error("write into a full queue");
    a_move_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_move_vld |-> (CNT_W'(r_rd_idx) + CNT_W'(1) < r_count))
        else $error("compaction write beyond the remaining entries");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites one not yet taken");

endmodule

[src/dispatch_rule_job_queue.sv]
// ----------------------------------------------------------------------------
// dispatch_rule_job_queue: job queue of one machine with a dispatch rule
// An add appends a job; a pick removes the job chosen by the rule.
// ----------------------------------------------------------------------------
// Steps, from the input transfer to a valid result: an add or an empty pick is
// dispatched and written out; a pick fetches the chosen entry and then moves or
// ages the M entries that remain, after N entries are scanned through the single
// memory read port for the time rules, or after 16 remainder steps for random.
// Throughput: one item at a time; the next input is taken once the result is
// in the output register. Reset empties the queue and sets the rule to FIFO.
// ----------------------------------------------------------------------------
module dispatch_rule_job_queue import drjq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata: job_id[7:0], proc_time[23:8], wait_in[43:24],
    // random_value[59:44], zero pad [63:60].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,   // op[0]
    // Result stream. tdata: picked_job[7:0], run_time[23:8].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // status[1:0]
    // Rule register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [STAT_W-1:0] out_status;
    logic [JOB_W-1:0]  out_job;
    logic [TIME_W-1:0] out_time;

    // The rule register is written at any time; the user is to make writes only
    // while the queue is idle (not enforced here); an operation then sees one rule.
    assign o_cfg_ready = 1'b1;

    drjq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    drjq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_rule   (i_cfg_data),
        .i_op         (i_s_tuser[0]),
        .i_job        (i_s_tdata[7:0]),
        .i_ptime      (i_s_tdata[23:8]),
        .i_wait       (i_s_tdata[43:24]),
        .i_rnd        (i_s_tdata[59:44]),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_status (out_status),
        .o_out_job    (out_job),
        .o_out_time   (out_time)
    );

    // Result payload, packed lowest field first.
    assign o_m_tdata = {out_time, out_job};
    assign o_m_tuser = out_status;

endmodule
